/* src/lcats_pkg.sv */
// ----------------------------------------------------------------------------
// lcats_pkg
// Types, widths and codes shared by the load cell averaging scale unit.
// ----------------------------------------------------------------------------
package lcats_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int SUM_W       = 32;
	localparam int CNT_W       = 7;
	localparam int GPC_W       = 48;
	localparam int COEF_W      = GPC_W / 2;
	localparam int GRAMS_W     = 48;
	localparam int MEAN_W      = 24;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int SCALED_W    = 58;
	localparam int MAG_W       = PROD_W + 8;
	localparam int DIV_CNT_W   = $clog2(SUM_W);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = GPC_W;

	localparam int DEFAULT_TARE_SAMPLES = 30;

	localparam logic [CFG_IDX_W-1:0] CFG_AVG_COUNT       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAMS_PER_COUNT = 1'd1;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

	typedef struct packed {
		logic                command;
		logic [SAMPLE_W-1:0] raw_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [GRAMS_W-1:0] grams_q16;
		logic signed [MEAN_W-1:0]  mean_counts;
		logic                      was_tare;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL_LO,
		S_MUL_HI,
		S_SCALE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic mul_lo;
		logic mul_hi;
		logic scale;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic run_done;
	} dp_sts_t;

endpackage

/* src/lcats_ctrl.sv */
// ----------------------------------------------------------------------------
// lcats_ctrl
// Sequencer: sample intake, divide iterations, scaling steps, result hand-off.
// ----------------------------------------------------------------------------
module lcats_ctrl import lcats_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	state_t                 state_q;
	state_t                 state_nxt;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   out_valid_q;
	logic                   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == S_IDLE);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && sts.run_done) begin
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_nxt = S_MUL_LO;
				end
			end
			S_MUL_LO: state_nxt = S_MUL_HI;
			S_MUL_HI: state_nxt = S_SCALE;
			S_SCALE:  state_nxt = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.accept   = in_valid;
			S_DIV:    cmd.div_step = 1'b1;
			S_MUL_LO: cmd.mul_lo   = 1'b1;
			S_MUL_HI: cmd.mul_hi   = 1'b1;
			S_SCALE:  cmd.scale    = 1'b1;
			S_OUT:    cmd.load_out = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/lcats_datapath.sv */
// ----------------------------------------------------------------------------
// lcats_datapath
// Run accumulator, bit-serial divider, shared 24x24 multiplier, tare offset.
// ----------------------------------------------------------------------------
module lcats_datapath import lcats_pkg::*; #(
	parameter int TARE_SAMPLES = DEFAULT_TARE_SAMPLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  in_item_t              in_item,
	output out_item_t             out_item,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts
);

	// configuration
	logic [CNT_W-1:0]           avg_count_q;
	logic [GPC_W-1:0]           gpc_q;

	// run state
	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           taken_q;
	logic                       is_tare_q;
	logic signed [GRAMS_W-1:0]  offset_q;

	// working registers
	logic                       neg_q;
	logic                       kind_q;
	logic [CNT_W-1:0]           div_q;
	logic [CNT_W-1:0]           rem_q;
	logic [SUM_W-1:0]           quo_q;
	logic [SUM_W-1:0]           part_q;
	logic [PROD_W-1:0]          prod_q;
	logic signed [SCALED_W-1:0] scaled_q;
	out_item_t                  out_q;

	logic signed [SUM_W-1:0]    sample_ext;
	logic                       restart;
	logic signed [SUM_W-1:0]    new_sum;
	logic [CNT_W-1:0]           new_n;
	logic [CNT_W-1:0]           target;
	logic [SUM_W-1:0]           sum_mag;
	logic [CNT_W:0]             trial;
	logic                       ge;
	logic [SAMPLE_W-1:0]        mag;
	logic [COEF_W-1:0]          coef;
	logic [PROD_W-1:0]          mul_res;
	logic [MAG_W-1:0]           r_mag;
	logic signed [SCALED_W-1:0] diff;
	logic signed [GRAMS_W-1:0]  sat;

	// sample intake
	always_comb begin
		sample_ext = $signed({{(SUM_W-SAMPLE_W){in_item.raw_sample[SAMPLE_W-1]}},
			in_item.raw_sample});
		restart    = (taken_q != '0) && (in_item.command != is_tare_q);
		new_sum    = (restart ? '0 : sum_q) + sample_ext;
		new_n      = (restart ? '0 : taken_q) + CNT_W'(1);
		target     = in_item.command ? CNT_W'(TARE_SAMPLES) : avg_count_q;
		if (target == '0) begin
			target = CNT_W'(1);
		end
		sts.run_done = (new_n >= target);
		sum_mag      = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
	end

	// one quotient bit per step
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = (trial >= {1'b0, div_q});

	// shared multiplier
	assign mag     = quo_q[SAMPLE_W-1:0];
	assign coef    = cmd.mul_hi ? gpc_q[GPC_W-1:COEF_W] : gpc_q[COEF_W-1:0];
	assign mul_res = PROD_W'(mag) * PROD_W'(coef);
	assign r_mag   = {prod_q, 8'd0} + MAG_W'(part_q);

	// offset and saturation
	always_comb begin
		if (kind_q) begin
			diff = scaled_q;
		end else begin
			diff = scaled_q - SCALED_W'(offset_q);
		end
		if ((diff[SCALED_W-1:GRAMS_W-1] == '0) || (diff[SCALED_W-1:GRAMS_W-1] == '1)) begin
			sat = diff[GRAMS_W-1:0];
		end else if (diff[SCALED_W-1]) begin
			sat = $signed({1'b1, {(GRAMS_W-1){1'b0}}});
		end else begin
			sat = $signed({1'b0, {(GRAMS_W-1){1'b1}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q <= CNT_W'(1);
			gpc_q       <= '0;
			sum_q       <= '0;
			taken_q     <= '0;
			is_tare_q   <= 1'b0;
			offset_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_idx)
					CFG_AVG_COUNT:       avg_count_q <= cfg_wdata[CNT_W-1:0];
					CFG_GRAMS_PER_COUNT: gpc_q       <= cfg_wdata[GPC_W-1:0];
					default:             gpc_q       <= gpc_q;
				endcase
			end
			if (cmd.accept) begin
				is_tare_q <= in_item.command;
				if (sts.run_done) begin
					sum_q   <= '0;
					taken_q <= '0;
				end else begin
					sum_q   <= new_sum;
					taken_q <= new_n;
				end
			end
			if (cmd.load_out && kind_q) begin
				offset_q <= sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.run_done) begin
			neg_q  <= new_sum[SUM_W-1];
			kind_q <= in_item.command;
			div_q  <= new_n;
			rem_q  <= '0;
			quo_q  <= sum_mag;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
		if (cmd.mul_lo) begin
			prod_q <= mul_res;
		end
		if (cmd.mul_hi) begin
			part_q <= SUM_W'(prod_q[PROD_W-1:16]);
			prod_q <= mul_res;
		end
		if (cmd.scale) begin
			scaled_q <= neg_q ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
		end
		if (cmd.load_out) begin
			out_q.grams_q16   <= sat;
			out_q.mean_counts <= neg_q ? $signed(MEAN_W'(-mag)) : $signed(mag);
			out_q.was_tare    <= kind_q;
		end
	end

	assign out_item = out_q;

endmodule

/* src/load_cell_average_tare_scale_unit.sv */
// ----------------------------------------------------------------------------
// load_cell_average_tare_scale_unit
// Averages load cell converter words over a run and scales them to grams.
// ----------------------------------------------------------------------------
// in channel: one beat per converter word (command, raw_sample). command 0
// adds to a measurement run of avg_count words, command 1 to a tare run of
// TARE_SAMPLES words; a change of command starts a new run with that word.
// A word that does not end a run is taken while in_ready stays high, so
// such words can stream back to back.
// A word that ends a run keeps in_ready low while the one-bit-per-cycle
// divider forms the mean, the shared 24x24 multiplier takes the low and
// high halves of the scale, one step forms sign and sum and one loads the
// output register, which waits while the previous beat is still there. The
// result beat is valid from the cycle after that load.
// out channel: one beat per finished run (grams_q16, mean_counts, was_tare).
// The output register holds a beat while the receiver stalls; the next run
// can be fed meanwhile, and its result waits until the register is free.
// cfg port: index 0 avg_count, index 1 grams_per_count; write while idle.
// Reset: avg_count 1, scale 0, tare offset 0, no run in progress, no beat.
// ----------------------------------------------------------------------------
module load_cell_average_tare_scale_unit import lcats_pkg::*; #(
	parameter int TARE_SAMPLES = DEFAULT_TARE_SAMPLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	lcats_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lcats_datapath #(
		.TARE_SAMPLES (TARE_SAMPLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

/* src/lcats_checker.sv */
// ----------------------------------------------------------------------------
// lcats_checker
// Port-level checks on the scale unit, bound to the top level.
// ----------------------------------------------------------------------------
module lcats_checker import lcats_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// a stalled beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_item))
		else $error("result beat changed while stalled");

	// a new result only comes out of the busy phase
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a busy phase");

	// a zero mean tare stores a zero offset
	a_zero_tare: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.was_tare && (out_item.mean_counts == '0)
		|-> (out_item.grams_q16 == '0))
		else $error("tare of zero mean gave a non-zero offset");

endmodule

bind load_cell_average_tare_scale_unit lcats_checker u_lcats_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
